// ===== hw/rtl/drks_pkg.sv =====
// Shared types and constants for the dynamic range k-th smallest block.
// No dependencies; imported by the cell, the top level and the checker.
package drks_pkg;

  localparam int POS_W  = 11;
  localparam int DATA_W = 32;

  localparam logic REQ_SET   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  // Query window broadcast to every cell.
  typedef struct packed {
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
  } qry_range_t;

endpackage

// ===== hw/rtl/drks_cell.sv =====
// One storage cell of the count chain: holds one value key and adds its
// match bit to the count passed on from its neighbor. Depends on drks_pkg.
module drks_cell #(
  parameter int IDX      = 0,
  parameter int IW       = 10,
  parameter int VB       = 32,
  parameter int CNT_W    = 11
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_idx,
  input  logic [VB-1:0]       wr_key,
  input  drks_pkg::qry_range_t rng,
  input  logic [VB-1:0]       prefix,
  input  logic [VB-1:0]       mask,
  input  logic [CNT_W-1:0]    cnt_in,
  output logic [CNT_W-1:0]    cnt_out
);
  import drks_pkg::*;

  localparam logic [31:0] PosNum = 32'(IDX + 1);

  logic [VB-1:0] key;
  logic          in_rng;
  logic          hit;

  assign in_rng = (32'(rng.lo) <= PosNum) && (PosNum <= 32'(rng.hi));
  assign hit    = in_rng && (((key ^ prefix) & mask) == '0);

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IW'(IDX))) begin
      key <= wr_key;
    end
    cnt_out <= cnt_in + CNT_W'(hit);
  end

endmodule

// ===== hw/rtl/dynamic_range_kth_smallest.sv =====
// Top level of the dynamic range k-th smallest block: request decode, the
// bit-by-bit search controller and the chain of drks_cell storage cells.
// Depends on drks_pkg and drks_cell.
//
//   channel | signals                          | carries
//   --------+----------------------------------+------------------------------
//   s_      | s_tvalid s_tready s_tdata s_tuser | set or query requests
//   m_      | m_tvalid m_tready m_tdata m_tuser | query answers
//   cfg_    | cfg_valid cfg_ready cfg_data      | active_count register
//
// A set request gives no answer. A valid query takes VALUE_BITS rounds:
// in every round the match count ripples one cell per cycle down the whole
// chain, so the chain length sets the round time. A bad query skips the
// search and is answered with an error status.
// Reset clears the control state and sets active_count to 1024; the stored
// values are undefined until written. While an answer waits on m_tready the
// block finishes its current query and then holds it until the slot frees.
module dynamic_range_kth_smallest #(
  parameter int MAX_ITEMS  = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // position[10:0], new_value[42:11], range_left[53:43], range_right[64:54],
  // rank_k[75:65], zero padding[79:76]
  input  logic [79:0] s_tdata,
  // req_type[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // kth_value[31:0]
  output logic [31:0] m_tdata,
  // status[0]
  output logic [0:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [drks_pkg::POS_W-1:0] cfg_data
);
  import drks_pkg::*;

  localparam int IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int BW    = $clog2(VALUE_BITS);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [VALUE_BITS-1:0] SignBit = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // Unpack the request fields.
  logic                   req_type;
  logic [POS_W-1:0]       position;
  logic signed [DATA_W-1:0] new_value;
  logic [POS_W-1:0]       range_left;
  logic [POS_W-1:0]       range_right;
  logic [POS_W-1:0]       rank_k;

  assign req_type    = s_tuser[0];
  assign position    = s_tdata[10:0];
  assign new_value   = s_tdata[42:11];
  assign range_left  = s_tdata[53:43];
  assign range_right = s_tdata[64:54];
  assign rank_k      = s_tdata[75:65];

  logic [POS_W-1:0]      active_count;
  logic [1:0]            state;
  logic [CNT_W-1:0]      sweep;
  logic [BW-1:0]         bitn;
  logic [VALUE_BITS-1:0] prefix;
  logic [POS_W-1:0]      rank;
  qry_range_t            rng;
  logic [DATA_W-1:0]     res_val;
  logic                  res_st;
  logic                  out_valid;
  logic [DATA_W-1:0]     out_val;
  logic                  out_st;

  // The configuration register is always writable; the user must keep the
  // block idle whenever it is written; the block itself does not enforce it.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= 11'd1024;
    end else if (cfg_valid) begin
      active_count <= cfg_data;
    end
  end

  // An active count past the store size behaves as if it were the size.
  logic [POS_W-1:0] lim;
  assign lim = (32'(active_count) > 32'(MAX_ITEMS)) ? POS_W'(MAX_ITEMS) : active_count;

  logic s_acc;
  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  // Set request: store the offset-binary key so that unsigned order of
  // keys matches signed order of values.
  logic                  wr_en;
  logic [IW-1:0]         wr_idx;
  logic [VALUE_BITS-1:0] wr_key;
  logic signed [VALUE_BITS-1:0] wr_val;

  assign wr_val = VALUE_BITS'(new_value);
  assign wr_key = wr_val ^ SignBit;
  assign wr_en  = s_acc && (req_type == REQ_SET) && (position != '0) && (position <= lim);
  assign wr_idx = IW'(position - POS_W'(1));

  // Query validity check.
  logic [POS_W:0] span;
  logic           bad_query;
  assign span      = {1'b0, range_right} - {1'b0, range_left} + (POS_W+1)'(1);
  assign bad_query = (range_left == '0) || (range_left > range_right) ||
                     (range_right > lim) || (rank_k == '0) ||
                     ({1'b0, rank_k} > span);

  // Cell chain. Each round compares every cell's key at and above the current
  // bit with the prefix found so far; counts ripple down one cell per cycle.
  logic [VALUE_BITS-1:0] mask;
  logic [CNT_W-1:0]      cnt [MAX_ITEMS+1];

  assign mask   = {VALUE_BITS{1'b1}} << bitn;
  assign cnt[0] = '0;

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    drks_cell #(
      .IDX   (g),
      .IW    (IW),
      .VB    (VALUE_BITS),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_key  (wr_key),
      .rng     (rng),
      .prefix  (prefix),
      .mask    (mask),
      .cnt_in  (cnt[g]),
      .cnt_out (cnt[g+1])
    );
  end

  // End-of-round decision on the current bit.
  logic [CNT_W-1:0]      total;
  logic                  go_up;
  logic [VALUE_BITS-1:0] prefix_next;
  logic [POS_W-1:0]      rank_next;
  logic signed [VALUE_BITS-1:0] final_val;

  assign total       = cnt[MAX_ITEMS];
  assign go_up       = CMP_W'(rank) > CMP_W'(total);
  assign prefix_next = go_up ? (prefix | (VALUE_BITS'(1) << bitn)) : prefix;
  assign rank_next   = go_up ? POS_W'(CMP_W'(rank) - CMP_W'(total)) : rank;
  assign final_val   = prefix_next ^ SignBit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In the done state the output slot is handled by the hand-off below.
      if (m_tready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_acc && (req_type == REQ_QUERY)) begin
            if (bad_query) begin
              res_val <= '0;
              res_st  <= ST_ERR;
              state   <= S_DONE;
            end else begin
              rng.lo <= range_left;
              rng.hi <= range_right;
              rank   <= rank_k;
              prefix <= '0;
              bitn   <= BW'(VALUE_BITS - 1);
              sweep  <= '0;
              state  <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (sweep == CNT_W'(MAX_ITEMS)) begin
            prefix <= prefix_next;
            rank   <= rank_next;
            sweep  <= '0;
            if (bitn == '0) begin
              res_val <= DATA_W'(final_val);
              res_st  <= ST_OK;
              state   <= S_DONE;
            end else begin
              bitn <= bitn - BW'(1);
            end
          end else begin
            sweep <= sweep + CNT_W'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_val   <= res_val;
            out_st    <= res_st;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_val;
  assign m_tuser[0] = out_st;

endmodule

// ===== hw/rtl/drks_checker.sv =====
// Port-level checks for dynamic_range_kth_smallest, bound to the top level.
// Depends on drks_pkg.
module drks_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);
  import drks_pkg::*;

  // No answer may appear right out of reset.
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("answer valid after reset");

  // A stalled answer holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled answer changed");

  // An error answer carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == ST_ERR) |-> m_tdata == '0)
    else $error("error answer with nonzero value");

  // A set request on an empty output never makes an answer.
  a_set_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == REQ_SET) && !m_tvalid |=> !m_tvalid)
    else $error("set request produced an answer");

endmodule

bind dynamic_range_kth_smallest drks_port_checks u_drks_port_checks (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
